// ----- rtl/core/prf_pkg.sv -----
// Shared types, constants and codes for the FIFO/LRU page replacement core.
`timescale 1ns / 1ps

package prf_pkg;

  // Page field width and page space (page numbers wrap inside this space)
  localparam int PAGE_W        = 5;
  localparam int VIRTUAL_PAGES = 32;

  // Frame parameter limits and defaults
  localparam int MAX_FRAMES_DEF  = 32;
  localparam int MAX_FRAMES_LIM  = 64;
  localparam int FIDX_W          = $clog2(MAX_FRAMES_LIM);
  localparam int COUNT_BITS_DEF  = 16;

  // Result field widths
  localparam int FRAME_OUT_W = 5;
  localparam int FCOUNT_W    = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 1'b1;
  localparam logic [CFG_DATA_W-1:0] FRAME_COUNT_RST = 6'd4;

  // Replacement policy codes
  localparam logic POL_FIFO = 1'b0;
  localparam logic POL_LRU  = 1'b1;

  // One page reference request
  typedef struct packed {
    logic              start_run;
    logic [PAGE_W-1:0] page_number;
  } req_t;

  // One reference result
  typedef struct packed {
    logic                   fault;
    logic [FRAME_OUT_W-1:0] frame_number;
    logic                   evicted_valid;
    logic [PAGE_W-1:0]      evicted_page;
    logic [FCOUNT_W-1:0]    fault_count;
  } res_t;

  // Broadcast command from the sequencer to every frame cell
  typedef struct packed {
    logic [PAGE_W-1:0] page;       // page looked up or written
    logic [FIDX_W:0]   used;       // frames in use now
    logic [FIDX_W:0]   limit;      // frames eligible as victims
    logic [FIDX_W-1:0] target;     // recency rank searched for
    logic [FIDX_W-1:0] sel_idx;    // frame read out on the select lane
    logic              touch_en;   // refresh recency around touch_idx
    logic              write_en;   // load page into frame touch_idx
    logic [FIDX_W-1:0] touch_idx;
    logic [FIDX_W-1:0] touch_old;  // rank the touched frame had
    logic [FIDX_W:0]   bound;      // frames that age on this touch
  } cell_cmd_t;

  // Data passed from cell to cell along the chain
  typedef struct packed {
    logic              hit;
    logic [FIDX_W-1:0] hit_idx;
    logic [FIDX_W-1:0] hit_rank;
    logic [PAGE_W-1:0] sel_owner;
    logic [FIDX_W-1:0] sel_rank;
    logic              fnd;
    logic [FIDX_W-1:0] fnd_idx;
  } cell_lnk_t;

endpackage

// ----- rtl/core/prf_cell.sv -----
// One frame cell: owner page and recency rank, with lookup and select lanes.
`timescale 1ns / 1ps

module prf_cell #(
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  prf_pkg::cell_cmd_t    cmd,
  input  prf_pkg::cell_lnk_t    lnk_i,
  output prf_pkg::cell_lnk_t    lnk_o
);
  import prf_pkg::*;

  localparam logic [FIDX_W-1:0] IDX_C = FIDX_W'(IDX);
  localparam logic [FIDX_W:0]   IDX_X = (FIDX_W+1)'(IDX);

  logic [PAGE_W-1:0] owner_r, owner_nxt;
  logic [FIDX_W-1:0] rank_r,  rank_nxt;
  logic              in_use;
  logic              match;
  logic              sel;
  logic              fmatch;

  // Compare against the broadcast command
  assign in_use = IDX_X < cmd.used;
  assign match  = in_use && (owner_r == cmd.page);
  assign sel    = (IDX_C == cmd.sel_idx);
  assign fmatch = (IDX_X < cmd.limit) && (rank_r == cmd.target);

  // Merge this cell's answers into the chain
  always_comb begin
    lnk_o           = lnk_i;
    lnk_o.hit       = lnk_i.hit | match;
    lnk_o.hit_idx   = lnk_i.hit_idx   | (match ? IDX_C : '0);
    lnk_o.hit_rank  = lnk_i.hit_rank  | (match ? rank_r : '0);
    lnk_o.sel_owner = lnk_i.sel_owner | (sel ? owner_r : '0);
    lnk_o.sel_rank  = lnk_i.sel_rank  | (sel ? rank_r : '0);
    lnk_o.fnd       = lnk_i.fnd | fmatch;
    lnk_o.fnd_idx   = lnk_i.fnd_idx   | (fmatch ? IDX_C : '0);
  end

  // Touch makes this frame newest or ages it; write loads a new owner
  always_comb begin
    owner_nxt = owner_r;
    rank_nxt  = rank_r;
    if (cmd.touch_en) begin
      if (IDX_C == cmd.touch_idx) begin
        rank_nxt = '0;
      end else if ((IDX_X < cmd.bound) && (rank_r < cmd.touch_old)) begin
        rank_nxt = rank_r + FIDX_W'(1);
      end
    end
    if (cmd.write_en && (IDX_C == cmd.touch_idx)) begin
      owner_nxt = cmd.page;
    end
  end

  always_ff @(posedge clk) begin
    owner_r <= owner_nxt;
    rank_r  <= rank_nxt;
  end

endmodule

// ----- rtl/core/page_replacement_fifo_lru_core.sv -----
// Page replacement core: one frame cell per frame with a sequencer at the head.
// A request passes the lookup (S_LOOK) and update (S_UPD) steps before the result
// strobes; an LRU eviction adds a find step (S_FIND) between them that repeats, one
// rank lower each time, when frame_count sits below the frames in use. The core takes
// no new request until the last one is through: busy drops in the cycle the result
// strobes, so the next request may start then. Synchronous active-low reset empties all
// frames, zeroes the fault count, sets frame_count 4, FIFO.
`timescale 1ns / 1ps

module page_replacement_fifo_lru_core #(
  parameter int MAX_FRAMES = prf_pkg::MAX_FRAMES_DEF,
  parameter int COUNT_BITS = prf_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  prf_pkg::req_t                  in_req,
  output logic                           out_valid,
  output prf_pkg::res_t                  out_res,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [prf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import prf_pkg::*;

  localparam logic [FIDX_W:0] MAXF = (FIDX_W+1)'(MAX_FRAMES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_FIND = 4'b0100,
    S_UPD  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic [FIDX_W:0]     used_r, used_nxt;
  logic [FIDX_W-1:0]   oldest_r, oldest_nxt;
  logic [COUNT_BITS-1:0] faults_r, faults_nxt;
  logic                hit_r, hit_nxt;
  logic                evict_r, evict_nxt;
  logic [FIDX_W-1:0]   victim_r, victim_nxt;
  logic [FIDX_W-1:0]   vrank_r, vrank_nxt;
  logic [FIDX_W-1:0]   target_r, target_nxt;
  logic [CFG_DATA_W-1:0] fcount_r;
  logic                policy_r;
  logic                out_valid_r, out_valid_nxt;
  res_t                out_res_r, out_res_nxt;

  logic [FIDX_W:0]     fc_ext;
  logic [FIDX_W:0]     n_lim;
  logic [FIDX_W-1:0]   osel;
  logic                accept;
  cell_cmd_t           cmd;
  cell_lnk_t           lnk [0:MAX_FRAMES];

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Clamp the configured frame count to 1..MAX_FRAMES
  assign fc_ext = (FIDX_W+1)'(fcount_r);
  always_comb begin
    if (fc_ext == '0) begin
      n_lim = (FIDX_W+1)'(1);
    end else if (fc_ext > MAXF) begin
      n_lim = MAXF;
    end else begin
      n_lim = fc_ext;
    end
  end

  // FIFO victim, wrapped when the count dropped below it
  assign osel = ({1'b0, oldest_r} >= n_lim) ? '0 : oldest_r;

  // Frame cell chain
  assign lnk[0] = '0;
  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    prf_cell #(.IDX(g)) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .lnk_i (lnk[g]),
      .lnk_o (lnk[g+1])
    );
  end

  // Drive the cell command for the current step
  always_comb begin
    cmd           = '0;
    cmd.page      = page_r;
    cmd.used      = used_r;
    cmd.limit     = n_lim;
    cmd.target    = target_r;
    cmd.sel_idx   = victim_r;
    cmd.touch_idx = victim_r;
    cmd.touch_old = vrank_r;
    cmd.bound     = used_r;
    if (state_r == S_LOOK) begin
      // read out the FIFO candidate's rank during lookup
      cmd.sel_idx = osel;
    end
    if (state_r == S_UPD) begin
      cmd.touch_en = 1'b1;
      cmd.write_en = !hit_r;
      if (!hit_r && !evict_r) begin
        // fill a free frame: every frame in use ages
        cmd.touch_old = used_r[FIDX_W-1:0];
        cmd.bound     = used_r + (FIDX_W+1)'(1);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    page_nxt      = page_r;
    used_nxt      = used_r;
    oldest_nxt    = oldest_r;
    faults_nxt    = faults_r;
    hit_nxt       = hit_r;
    evict_nxt     = evict_r;
    victim_nxt    = victim_r;
    vrank_nxt     = vrank_r;
    target_nxt    = target_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          page_nxt = in_req.page_number;
          if (in_req.start_run) begin
            used_nxt   = '0;
            oldest_nxt = '0;
            faults_nxt = '0;
          end
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        hit_nxt   = lnk[MAX_FRAMES].hit;
        evict_nxt = 1'b0;
        if (lnk[MAX_FRAMES].hit) begin
          victim_nxt = lnk[MAX_FRAMES].hit_idx;
          vrank_nxt  = lnk[MAX_FRAMES].hit_rank;
          state_nxt  = S_UPD;
        end else begin
          if (faults_r != '1) begin
            faults_nxt = faults_r + COUNT_BITS'(1);
          end
          if (used_r < n_lim) begin
            victim_nxt = used_r[FIDX_W-1:0];
            state_nxt  = S_UPD;
          end else if (policy_r == POL_LRU) begin
            target_nxt = FIDX_W'(used_r - (FIDX_W+1)'(1));
            state_nxt  = S_FIND;
          end else begin
            victim_nxt = osel;
            vrank_nxt  = lnk[MAX_FRAMES].sel_rank;
            evict_nxt  = 1'b1;
            oldest_nxt = (({1'b0, osel} + (FIDX_W+1)'(1)) >= n_lim) ? '0
                         : osel + FIDX_W'(1);
            state_nxt  = S_UPD;
          end
        end
      end
      S_FIND: begin
        // step the rank down until an eligible frame holds it
        if (lnk[MAX_FRAMES].fnd) begin
          victim_nxt = lnk[MAX_FRAMES].fnd_idx;
          vrank_nxt  = target_r;
          evict_nxt  = 1'b1;
          state_nxt  = S_UPD;
        end else begin
          target_nxt = target_r - FIDX_W'(1);
        end
      end
      S_UPD: begin
        if (!hit_r && !evict_r) begin
          used_nxt = used_r + (FIDX_W+1)'(1);
        end
        out_valid_nxt             = 1'b1;
        out_res_nxt.fault         = !hit_r;
        out_res_nxt.frame_number  = FRAME_OUT_W'(victim_r);
        out_res_nxt.evicted_valid = evict_r;
        out_res_nxt.evicted_page  = evict_r ? lnk[MAX_FRAMES].sel_owner : '0;
        out_res_nxt.fault_count   = FCOUNT_W'(faults_r);
        state_nxt                 = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      oldest_r    <= '0;
      faults_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      oldest_r    <= oldest_nxt;
      faults_r    <= faults_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request payload and result registers
  always_ff @(posedge clk) begin
    page_r    <= page_nxt;
    hit_r     <= hit_nxt;
    evict_r   <= evict_nxt;
    victim_r  <= victim_nxt;
    vrank_r   <= vrank_nxt;
    target_r  <= target_nxt;
    out_res_r <= out_res_nxt;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcount_r <= FRAME_COUNT_RST;
      policy_r <= POL_FIFO;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_COUNT: fcount_r <= cfg_data;
        CFG_POLICY:      policy_r <= cfg_data[0];
        default:         fcount_r <= fcount_r;
      endcase
    end
  end

endmodule
